// File: src/psv_pkg.sv
// Package for the plucked-string voice: sequencer state type, register
// indexes and fixed field widths. No dependencies.
`default_nettype none

package psv_pkg;

    localparam int EXC_W       = 16;
    localparam int DLEN_W      = 12;
    localparam int GAIN_W      = 17;
    localparam int COEFF_W     = 16;
    localparam int CFG_DATA_W  = 17;
    localparam int CFG_INDEX_W = 2;

    localparam logic [GAIN_W-1:0]  GAIN_UNITY   = 17'd65536;
    localparam logic [GAIN_W-1:0]  GAIN_RESET   = 17'd64565;
    localparam logic [DLEN_W-1:0]  DLEN_RESET   = 12'd100;
    localparam logic [COEFF_W-1:0] COEFF_RESET  = 16'd16384;

    localparam logic [CFG_INDEX_W-1:0] REG_DELAY_LENGTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LOOP_GAIN     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ALLPASS_COEFF = 2'd2;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL1 = 6'b000010,
        S_ACC  = 6'b000100,
        S_LP   = 6'b001000,
        S_MUL2 = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

endpackage

`default_nettype wire

// File: src/plucked_string_voice.sv
// Plucked-string voice top level: delay line, sequencer and shared multiplier.
// Depends on psv_pkg.
//
// The block takes one excitation beat on the input channel (in_valid/in_ready)
// and returns one beat on the output channel (out_valid/out_ready) carrying
// the filtered sample and the running peak magnitude. Configuration registers
// are written through cfg_write/cfg_index/cfg_data, only while the block is
// idle, which the user must ensure: the block does not enforce it. An accepted
// beat starts the delay-line read and then passes five sequencer steps:
// feedback multiply, excitation sum, lowpass, allpass multiply and commit.
// One multiplier is shared by the feedback and allpass products, and a new
// beat is not accepted until the previous one has committed. If the output
// register still holds an untaken beat, the commit step waits, and the input
// stays not ready.
// Reset clears the filter states, fill count, ring pointer, peak and the
// output valid, and loads the default register values. The delay memory is
// not cleared; reads are gated by the fill count until it has been written.
`default_nettype none

module plucked_string_voice
    import psv_pkg::*;
#(
    parameter int MAX_DELAY   = 4096,
    parameter int SAMPLE_BITS = 24
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write,
    input  wire logic [CFG_INDEX_W-1:0]             cfg_index,
    input  wire logic [CFG_DATA_W-1:0]              cfg_data,
    input  wire logic                               in_valid,
    output      logic                               in_ready,
    input  wire logic signed [EXC_W-1:0]            excitation,
    input  wire logic                               note_start,
    input  wire logic                               clear_peak,
    output      logic                               out_valid,
    input  wire logic                               out_ready,
    output      logic signed [SAMPLE_BITS-1:0]      sample,
    output      logic [SAMPLE_BITS-2:0]             peak
);

    localparam int AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int FW = $clog2(MAX_DELAY + 1);
    localparam int WW = SAMPLE_BITS + 3;
    localparam int MW = SAMPLE_BITS + 1;
    localparam int PW = MW + 18;

    localparam logic signed [WW-1:0] SMAX_W = $signed({4'b0000, {(SAMPLE_BITS-1){1'b1}}});
    localparam logic signed [WW-1:0] SMIN_W = $signed({4'b1111, {(SAMPLE_BITS-1){1'b0}}});
    localparam logic signed [SAMPLE_BITS-1:0] SMIN_S =
        $signed({1'b1, {(SAMPLE_BITS-1){1'b0}}});

    function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [WW-1:0] v);
        logic signed [SAMPLE_BITS-1:0] r;
        if (v > SMAX_W)
            r = SMAX_W[SAMPLE_BITS-1:0];
        else if (v < SMIN_W)
            r = SMIN_W[SAMPLE_BITS-1:0];
        else
            r = v[SAMPLE_BITS-1:0];
        return r;
    endfunction

    state_t state_reg, state_next;

    logic [DLEN_W-1:0]               dlen_reg;
    logic [GAIN_W-1:0]               gain_reg;
    logic signed [COEFF_W-1:0]       coeff_reg;

    logic [FW-1:0]                   fill_reg;
    logic [AW-1:0]                   ptr_reg;
    logic signed [SAMPLE_BITS-1:0]   lpp_reg;
    logic signed [SAMPLE_BITS-1:0]   api_reg;
    logic signed [SAMPLE_BITS-1:0]   apo_reg;
    logic [SAMPLE_BITS-2:0]          peak_mag_reg;

    logic signed [EXC_W-1:0]         x_reg;
    logic                            hit_reg;
    logic signed [SAMPLE_BITS-1:0]   rd_data_reg;
    logic signed [PW-1:0]            prod_reg;
    logic signed [SAMPLE_BITS-1:0]   s_reg;
    logic signed [SAMPLE_BITS-1:0]   lp_reg;

    logic                            out_valid_reg;
    logic signed [SAMPLE_BITS-1:0]   sample_reg;
    logic [SAMPLE_BITS-2:0]          peak_reg;

    logic [SAMPLE_BITS-1:0]          mem [MAX_DELAY];

    logic                            accept;
    logic                            commit;
    logic [FW-1:0]                   len_eff;
    logic [GAIN_W-1:0]               gain_eff;
    logic [FW:0]                     ptr_ext;
    logic [FW:0]                     rd_wide;
    logic [AW-1:0]                   rd_idx;

    logic signed [MW-1:0]            mul_a;
    logic signed [17:0]              mul_b;

    logic signed [PW-1:0]            rnd1;
    logic signed [WW-1:0]            fb;
    logic signed [WW-1:0]            s_w;
    logic signed [WW-1:0]            lp_sum;
    logic signed [WW-1:0]            lp_rnd;
    logic signed [PW-1:0]            rnd2;
    logic signed [WW-1:0]            ap;
    logic signed [WW-1:0]            y_w;
    logic signed [SAMPLE_BITS-1:0]   y;
    logic [SAMPLE_BITS-2:0]          y_mag;

    assign accept = in_valid && in_ready;
    assign commit = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign peak      = peak_reg;

    always_comb
    begin
        if (dlen_reg == '0)
            len_eff = FW'(1);
        else if (32'(dlen_reg) > 32'(MAX_DELAY))
            len_eff = FW'(MAX_DELAY);
        else
            len_eff = FW'(dlen_reg);
    end

    assign gain_eff = (gain_reg > GAIN_UNITY) ? GAIN_UNITY : gain_reg;

    assign ptr_ext = (FW+1)'(ptr_reg);
    always_comb
    begin
        if (ptr_ext >= (FW+1)'(len_eff))
            rd_wide = ptr_ext - (FW+1)'(len_eff);
        else
            rd_wide = ptr_ext + (FW+1)'(MAX_DELAY) - (FW+1)'(len_eff);
    end
    assign rd_idx = rd_wide[AW-1:0];

    always_comb
    begin
        if (state_reg == S_MUL2)
        begin
            mul_a = MW'(lp_reg) - MW'(apo_reg);
            mul_b = 18'(coeff_reg);
        end
        else
        begin
            mul_a = hit_reg ? MW'(rd_data_reg) : '0;
            mul_b = $signed({1'b0, gain_eff});
        end
    end

    assign rnd1   = prod_reg + $signed(PW'(32768)) - $signed(PW'(prod_reg[PW-1]));
    assign fb     = rnd1[PW-1:16];
    assign s_w    = WW'(x_reg) + fb;

    assign lp_sum = WW'(s_reg) + WW'(lpp_reg);
    assign lp_rnd = lp_sum + $signed(WW'(1)) - $signed(WW'(lp_sum[WW-1]));

    assign rnd2   = prod_reg + $signed(PW'(8192)) - $signed(PW'(prod_reg[PW-1]));
    assign ap     = rnd2[WW+13:14];
    assign y_w    = WW'(api_reg) + ap;
    assign y      = sat(y_w);

    always_comb
    begin
        if (y == SMIN_S)
            y_mag = '1;
        else if (y < 0)
            y_mag = (SAMPLE_BITS-1)'(-y);
        else
            y_mag = y[SAMPLE_BITS-2:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept) state_next = S_MUL1;
            S_MUL1:  state_next = S_ACC;
            S_ACC:   state_next = S_LP;
            S_LP:    state_next = S_MUL2;
            S_MUL2:  state_next = S_OUT;
            S_OUT:   if (commit) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dlen_reg      <= DLEN_RESET;
            gain_reg      <= GAIN_RESET;
            coeff_reg     <= COEFF_RESET;
            fill_reg      <= '0;
            ptr_reg       <= '0;
            lpp_reg       <= '0;
            api_reg       <= '0;
            apo_reg       <= '0;
            peak_mag_reg  <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write)
            begin
                case (cfg_index)
                    REG_DELAY_LENGTH:  dlen_reg  <= cfg_data[DLEN_W-1:0];
                    REG_LOOP_GAIN:     gain_reg  <= cfg_data[GAIN_W-1:0];
                    REG_ALLPASS_COEFF: coeff_reg <= cfg_data[COEFF_W-1:0];
                    default:           ;
                endcase
            end

            if (accept)
            begin
                hit_reg <= !note_start && (fill_reg >= len_eff);
                if (note_start)
                begin
                    fill_reg <= '0;
                    lpp_reg  <= '0;
                    api_reg  <= '0;
                    apo_reg  <= '0;
                end
                if (clear_peak)
                    peak_mag_reg <= '0;
            end

            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            if (commit)
            begin
                lpp_reg <= s_reg;
                api_reg <= lp_reg;
                apo_reg <= y;
                if (ptr_reg == AW'(MAX_DELAY - 1))
                    ptr_reg <= '0;
                else
                    ptr_reg <= ptr_reg + AW'(1);
                if (fill_reg < FW'(MAX_DELAY))
                    fill_reg <= fill_reg + FW'(1);
                if (y_mag > peak_mag_reg)
                    peak_mag_reg <= y_mag;
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            x_reg <= excitation;
        if (state_reg == S_MUL1 || state_reg == S_MUL2)
            prod_reg <= mul_a * mul_b;
        if (state_reg == S_ACC)
            s_reg <= sat(s_w);
        if (state_reg == S_LP)
            lp_reg <= lp_rnd[SAMPLE_BITS:1];
        if (commit)
        begin
            sample_reg <= y;
            peak_reg   <= (y_mag > peak_mag_reg) ? y_mag : peak_mag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
            mem[ptr_reg] <= y;
        if (accept)
            rd_data_reg <= mem[rd_idx];
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_MUL1) && !in_ready)
        else $error("accepted beat did not start the sequencer");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(MAX_DELAY))
        else $error("fill count ran past the delay store depth");

    a_peak_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        !(accept && clear_peak) |=> peak_mag_reg >= $past(peak_mag_reg))
        else $error("peak magnitude fell without a clear");

endmodule

`default_nettype wire
